>>> hw/rtl/dqss_pkg.sv
`default_nettype none
package dqss_pkg;

    localparam int DEPTH = 16;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_STATS      = 3'd5
    } req_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_index;
        logic [4:0]         fill_count;
        logic signed [23:0] mean_q8;
        logic [23:0]        std_dev_q8;
    } out_item_t;

    // one cell's command from the controller
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/dqss_cell.sv
`default_nettype none
module dqss_cell (
    input  wire logic                     clk,
    input  wire dqss_pkg::cell_ctl_t      ctl,
    input  wire logic signed [15:0]       load_value,
    input  wire logic signed [15:0]       left_value,
    input  wire logic signed [15:0]       right_value,
    output logic signed [15:0]            value
);
    import dqss_pkg::*;

    logic signed [15:0] value_reg;
    logic signed [15:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = load_value;
        end
        else if (ctl.shift_right)
        begin
            value_next = left_value;
        end
        else if (ctl.shift_left)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
endmodule
`default_nettype wire

>>> hw/rtl/dqss_divsqrt.sv
`default_nettype none
// restoring divider followed by bit-pair square root, one step per cycle
module dqss_divsqrt (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [55:0]  num,
    input  wire logic [47:0]  den,
    output logic              done,
    output logic [23:0]       root
);
    import dqss_pkg::*;

    typedef enum logic [2:0] {
        DS_IDLE = 3'b001,
        DS_DIV  = 3'b010,
        DS_SQRT = 3'b100
    } ds_state_t;

    ds_state_t   state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [55:0] quo_reg, quo_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] den_reg, den_next;
    logic [24:0] res_reg, res_next;
    logic [25:0] srem_reg, srem_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic [25:0] strial;
    logic [25:0] spart;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        res_next   = res_reg;
        srem_next  = srem_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, quo_reg[55]};
        spart      = {srem_reg[23:0], quo_reg[47:46]};
        strial     = {res_reg[23:0], 2'b01};
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    quo_next   = num;
                    rem_next   = '0;
                    den_next   = den;
                    step_next  = 6'd55;
                    state_next = DS_DIV;
                end
            end
            DS_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 48'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[54:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[47:0];
                    quo_next = {quo_reg[54:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    res_next   = '0;
                    srem_next  = '0;
                    step_next  = 6'd23;
                    state_next = DS_SQRT;
                end
                else
                begin
                    step_next = step_reg - 6'd1;
                end
            end
            DS_SQRT:
            begin
                // quotient stays below 2^47, so its top bits are zero and the root fits 24 bits
                quo_next = {quo_reg[53:0], 2'b00};
                if (spart >= strial)
                begin
                    srem_next = spart - strial;
                    res_next  = {res_reg[23:0], 1'b1};
                end
                else
                begin
                    srem_next = spart;
                    res_next  = {res_reg[23:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = DS_IDLE;
                end
                else
                begin
                    step_next = step_reg - 6'd1;
                end
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        res_reg  <= res_next;
        srem_reg <= srem_next;
    end

    assign done = done_reg;
    assign root = res_reg[23:0];

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divsqrt done held");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DS_IDLE && start) |=> state_reg == DS_DIV)
        else $error("divsqrt did not start");
    a_done_from_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg) == DS_SQRT)
        else $error("divsqrt done without root");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/deque_with_search_and_stats.sv
`default_nettype none
// Bounded deque of sixteen signed 16-bit values held in a row of cells that
// shift together for pushes and pops at the front. Push and pop stall the input
// through the execute and output states after an item is taken, a search walks
// the cells one per cycle, and statistics run a 56-step divider then a 24-step
// square root; the mean is divided out bit by bit alongside. One item is worked
// on at a time; its result moves to an output register once that register is
// free, and the next item is taken right after, so a stalled result overlaps
// the work on the next item.
module deque_with_search_and_stats (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire dqss_pkg::in_item_t    in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output dqss_pkg::out_item_t        out_data
);
    import dqss_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_SEARCH = 6'b000100,
        S_MUL    = 6'b001000,
        S_DIVS   = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    in_item_t            req_reg, req_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [20:0]  sum_reg, sum_next;
    logic [34:0]         sumsq_reg, sumsq_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;
    out_item_t           res_reg, res_next;
    logic [55:0]         num_reg, num_next;
    logic [47:0]         den_reg, den_next;
    logic [20:0]         mag_reg, mag_next;
    logic [47:0]         psum_reg, psum_next;
    logic [1:0]          mstep_reg, mstep_next;
    logic [28:0]         mq_reg, mq_next;
    logic [4:0]          mr_reg, mr_next;
    logic [4:0]          mdstep_reg, mdstep_next;
    logic [5:0]          mtrial;
    logic [20:0]         sum_mag;
    logic                ds_start;
    logic                ds_done;
    logic [23:0]         ds_root;

    logic signed [15:0]  cell_val [DEPTH];
    cell_ctl_t           cell_ctl [DEPTH];
    logic signed [15:0]  pop_val;
    logic signed [31:0]  pop_sq;
    logic signed [31:0]  push_sq;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [15:0] lv, rv;
            if (g == 0)
            begin : g_l
                assign lv = req_reg.value;
            end
            else
            begin : g_l
                assign lv = cell_val[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_r
                assign rv = cell_val[g];
            end
            else
            begin : g_r
                assign rv = cell_val[g+1];
            end
            dqss_cell u_cell (
                .clk(clk),
                .ctl(cell_ctl[g]),
                .load_value(req_reg.value),
                .left_value(lv),
                .right_value(rv),
                .value(cell_val[g])
            );
        end
    endgenerate

    dqss_divsqrt u_divsqrt (
        .clk(clk),
        .rst_n(rst_n),
        .start(ds_start),
        .num(num_reg),
        .den(den_reg),
        .done(ds_done),
        .root(ds_root)
    );

    // back item lives at count-1; search compares the indexed cell, rotating
    // left is avoided by indexing the fixed cell array with the walk index
    logic [IW-1:0] back_idx;
    logic          walk_hit;
    assign back_idx = IW'(count_reg - CW'(1));
    assign pop_val  = (req_reg.req_type == REQ_POP_FRONT) ? cell_val[0] : cell_val[back_idx];
    assign pop_sq   = pop_val * pop_val;
    assign push_sq  = req_reg.value * req_reg.value;
    assign walk_hit = cell_val[idx_reg] == req_reg.value;
    assign sum_mag  = sum_reg[20] ? 21'(-sum_reg) : 21'(sum_reg);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        mag_next       = mag_reg;
        psum_next      = psum_reg;
        mstep_next     = mstep_reg;
        mq_next        = mq_reg;
        mr_next        = mr_reg;
        mdstep_next    = mdstep_reg;
        mtrial         = {mr_reg, mq_reg[28]};
        ds_start       = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            cell_ctl[k] = '0;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        // mean divider, one quotient bit a cycle while the products and the main divider run
        if (mdstep_reg != '0)
        begin
            if (mtrial >= {1'b0, count_reg})
            begin
                mr_next = 5'(mtrial - {1'b0, count_reg});
                mq_next = {mq_reg[27:0], 1'b1};
            end
            else
            begin
                mr_next = mtrial[4:0];
                mq_next = {mq_reg[27:0], 1'b0};
            end
            mdstep_next = mdstep_reg - 5'd1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next             = '0;
                res_next.fill_count  = 5'(count_reg);
                state_next           = S_OUT;
                case (req_reg.req_type)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            for (int k = 0; k < DEPTH; k++)
                            begin
                                if (req_reg.req_type == REQ_PUSH_FRONT)
                                begin
                                    cell_ctl[k].shift_right = 1'b1;
                                end
                                else if (CW'(k) == count_reg)
                                begin
                                    cell_ctl[k].load = 1'b1;
                                end
                            end
                            count_next = count_reg + CW'(1);
                            sum_next   = sum_reg + 21'(req_reg.value);
                            sumsq_next = sumsq_reg + 35'(unsigned'(push_sq));
                            res_next.fill_count = 5'(count_reg + CW'(1));
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            if (req_reg.req_type == REQ_POP_FRONT)
                            begin
                                for (int k = 0; k < DEPTH; k++)
                                begin
                                    cell_ctl[k].shift_left = 1'b1;
                                end
                            end
                            count_next = count_reg - CW'(1);
                            sum_next   = sum_reg - 21'(pop_val);
                            sumsq_next = sumsq_reg - 35'(unsigned'(pop_sq));
                            res_next.fill_count = 5'(count_reg - CW'(1));
                        end
                    end
                    REQ_SEARCH:
                    begin
                        idx_next = '0;
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_NOTFOUND;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    REQ_STATS:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            mag_next    = sum_mag;
                            mq_next     = {sum_mag, 8'd0};
                            mr_next     = '0;
                            mdstep_next = 5'd29;
                            mstep_next  = '0;
                            state_next  = S_MUL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (walk_hit)
                begin
                    res_next.status      = ST_OK;
                    res_next.found_index = 4'(idx_reg);
                    state_next           = S_OUT;
                end
                else if (CW'(idx_reg) + CW'(1) >= count_reg)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next      = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_MUL:
            begin
                // products by step: c*sumsq, then mag^2 (subtracted from it) together with c*c
                unique case (mstep_reg)
                    2'd0: psum_next = 48'(count_reg) * 48'(sumsq_reg);
                    2'd1:
                    begin
                        psum_next = 48'(psum_reg - 48'(mag_reg) * 48'(mag_reg));
                        den_next  = 48'(10'(count_reg) * 10'(count_reg));
                    end
                    2'd2:
                    begin
                        num_next  = {psum_reg[39:0], 16'd0};
                    end
                    default:
                    begin
                        ds_start   = 1'b1;
                        state_next = S_DIVS;
                    end
                endcase
                mstep_next = mstep_reg + 2'd1;
            end
            S_DIVS:
            begin
                if (ds_done)
                begin
                    res_next.mean_q8    = sum_reg[20] ? -24'(mq_reg) : 24'(mq_reg);
                    res_next.std_dev_q8 = ds_root;
                    state_next          = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            out_valid_reg <= 1'b0;
            mdstep_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sumsq_reg     <= sumsq_next;
            out_valid_reg <= out_valid_next;
            mdstep_reg    <= mdstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        out_reg   <= out_next;
        res_reg   <= res_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        mag_reg   <= mag_next;
        psum_reg  <= psum_next;
        mstep_reg <= mstep_next;
        mq_reg    <= mq_next;
        mr_reg    <= mr_next;
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EXEC |=> count_reg == $past(count_reg))
        else $error("fill count moved outside execute");
    a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> (sum_reg == '0 && sumsq_reg == '0))
        else $error("sums nonzero when empty");
    a_mean_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ds_done |-> mdstep_reg == '0)
        else $error("mean not ready with root");
`endif
endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
class deque_scoreboard;
    logic signed [15:0] slots[$];
    logic signed [63:0] sum;
    logic [63:0] sumsq;
    dqss_pkg::out_item_t pending[$];
    int errors;

    function new();
        sum = 0;
        sumsq = 0;
        errors = 0;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function void note_request(dqss_pkg::in_item_t it);
        dqss_pkg::out_item_t r;
        logic signed [15:0] v;
        logic signed [63:0] m;
        logic [63:0] mag;
        logic [63:0] c;
        logic [63:0] vn;
        r = '0;
        v = it.value;
        case (it.req_type)
            dqss_pkg::REQ_PUSH_FRONT, dqss_pkg::REQ_PUSH_BACK:
                if (slots.size() >= dqss_pkg::DEPTH)
                    r.status = dqss_pkg::ST_FULL;
                else
                begin
                    if (it.req_type == dqss_pkg::REQ_PUSH_FRONT)
                        slots.insert(0, v);
                    else
                        slots.insert(slots.size(), v);
                    sum = sum + v;
                    sumsq = sumsq + 64'(v * v);
                end
            dqss_pkg::REQ_POP_FRONT, dqss_pkg::REQ_POP_BACK:
                if (slots.size() == 0)
                    r.status = dqss_pkg::ST_EMPTY;
                else
                begin
                    if (it.req_type == dqss_pkg::REQ_POP_FRONT)
                    begin
                        v = slots[0];
                        slots.delete(0);
                    end
                    else
                    begin
                        v = slots[slots.size() - 1];
                        slots.delete(slots.size() - 1);
                    end
                    sum = sum - v;
                    sumsq = sumsq - 64'(v * v);
                end
            dqss_pkg::REQ_SEARCH:
            begin
                r.status = dqss_pkg::ST_NOTFOUND;
                for (int i = 0; i < slots.size(); i++)
                    if (slots[i] == v)
                    begin
                        r.status = dqss_pkg::ST_OK;
                        r.found_index = 4'(i);
                        break;
                    end
            end
            dqss_pkg::REQ_STATS:
                if (slots.size() == 0)
                    r.status = dqss_pkg::ST_EMPTY;
                else
                begin
                    c = slots.size();
                    mag = (sum < 0) ? 64'(-sum) : 64'(sum);
                    vn = c * sumsq - mag * mag;
                    m = (sum * 256) / $signed(c);
                    r.mean_q8 = 24'(m);
                    r.std_dev_q8 = 24'(int_sqrt((vn * 65536) / (c * c)));
                end
            default: ;
        endcase
        r.fill_count = 5'(slots.size());
        pending.insert(pending.size(), r);
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_result(dqss_pkg::out_item_t got);
        dqss_pkg::out_item_t want;
        if (pending.size() == 0)
        begin
            report("unexpected item", 0, 0);
            return;
        end
        want = pending[0];
        pending.delete(0);
        if (got.status != want.status)
            report("status", got.status, want.status);
        if (got.found_index != want.found_index)
            report("found_index", got.found_index, want.found_index);
        if (got.fill_count != want.fill_count)
            report("fill_count", got.fill_count, want.fill_count);
        if (got.mean_q8 != want.mean_q8)
            report("mean_q8", got.mean_q8, want.mean_q8);
        if (got.std_dev_q8 != want.std_dev_q8)
            report("std_dev_q8", got.std_dev_q8, want.std_dev_q8);
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqss_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;

    deque_scoreboard board = new();
    int idle_cycles = 0;
    bit in_done = 1'b0;
    bit sink_quiet = 1'b0;

    localparam int WATCHDOG = 20000;

    deque_with_search_and_stats dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // one item, held until accepted
    task send_item(input logic [2:0] kind, input logic signed [15:0] v);
        in_item_t it;
        it.req_type = kind;
        it.value = v;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(it);
    endtask

    task send_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // accept at the edge, check with the values sampled there
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || sink_quiet)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 30)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        logic [2:0] op;
        int r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, full, every opcode incl unused
        send_item(REQ_POP_FRONT, 16'sd0);
        send_item(REQ_POP_BACK, 16'sd0);
        send_item(REQ_STATS, 16'sd0);
        send_item(REQ_SEARCH, 16'sd5);
        send_item(3'd6, 16'sd1);
        send_item(3'd7, -16'sd1);
        send_item(REQ_PUSH_BACK, 16'sh7fff);
        send_item(REQ_STATS, 16'sd0);
        for (int i = 0; i < 15; i++)
            send_item((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                (i % 3 == 0) ? 16'sh8000 : 16'sh7fff);
        send_item(REQ_PUSH_FRONT, 16'sd1);
        send_item(REQ_STATS, 16'sd0);
        send_item(REQ_SEARCH, 16'sh8000);
        drain_results();

        while (board.slots.size() > 0)
            send_item(REQ_POP_FRONT, 16'sd0);

        for (int k = 0; k < 1950; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = (board.slots.size() < 12 || $urandom_range(0, 3) == 0)
                    ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 3));
            else if (r < 62)
                op = 3'($urandom_range(2, 3));
            else if (r < 80)
                op = REQ_SEARCH;
            else if (r < 97)
                op = REQ_STATS;
            else
                op = 3'($urandom_range(6, 7));
            if (op == REQ_SEARCH && board.slots.size() > 0 && $urandom_range(0, 2) != 0)
                send_item(op, board.slots[$urandom_range(0, board.slots.size() - 1)]);
            else
                send_item(op, pick_value());
            send_gap(gap_len());
            if (k == 900)
            begin
                sink_quiet = 1'b1;
                drain_results();
                sink_quiet = 1'b0;
            end
        end
        in_valid <= 1'b0;
        in_done = 1'b1;
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG)
            begin
                $display("tb: failure");
                $finish;
            end
            if (in_done && board.pending.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (board.errors == 0 && board.pending.size() == 0)
                    $display("tb: success");
                else
                    $display("tb: failure");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/dqss_pkg.sv
hw/rtl/dqss_cell.sv
hw/rtl/dqss_divsqrt.sv
hw/rtl/deque_with_search_and_stats.sv
tb/tb.sv
